// ----- hdl/speo_pkg.sv -----
package speo_pkg;

   // fixed field widths of the request and response items
   localparam int SLOT_W = 5;

   // request action codes
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_EXEC = 5'b00010,
      ST_LINK = 5'b00100,
      ST_PUSH = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   // what the accepted item turned out to be
   typedef enum logic [1:0] {
      OP_TAKE    = 2'd0,  // allocate from the free list
      OP_RECLAIM = 2'd1,  // allocate by evicting the oldest live slot
      OP_RELEASE = 2'd2,  // free of a live slot
      OP_REJECT  = 2'd3   // free of a slot that is not live
   } op_type;

endpackage

// ----- hdl/speo_link_ram.sv -----
module speo_link_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/slot_pool_evict_oldest_core.sv -----
// Slot pool allocator with eviction of the oldest live slot. An allocate item
// takes the top of the free list, or, once every slot is live, reclaims the
// oldest live slot (rsp_reclaimed high); the granted slot becomes the newest
// on a doubly linked age list. A free item unlinks a live slot and pushes it
// on the free list; freeing a slot that is not live changes nothing and
// raises rsp_bad_free, echoing the slot number. The newer and older links of
// every slot sit in two one-port-write RAMs with registered reads; the ends of
// the age list, the free list top and the live bits sit in flops. The free
// chain shares the newer-link RAM (a free slot has no age neighbours) and a
// written bit per slot stands in for its reset contents, so no clearing pass
// is needed. Each item is one at a time: an allocate or a good free passes
// through the execute state and then a link or push state, because the
// newer-link RAM needs two writes per item through its single write port;
// a rejected free goes from idle straight to done. The response register
// lets the next item start while a result still waits on rsp_ready.
module slot_pool_evict_oldest_core
   import speo_pkg::*;
#(
   parameter int POOL_SLOTS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   input  logic [SLOT_W-1:0] req_slot_to_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SLOT_W-1:0] rsp_slot_index,
   output logic              rsp_reclaimed,
   output logic              rsp_bad_free
);

   // node width holds a slot number or the sentinel / none code
   localparam int NW = $clog2(POOL_SLOTS + 1);
   localparam int SW = $clog2(POOL_SLOTS);
   localparam int XW = (NW > SLOT_W) ? NW : SLOT_W;
   localparam logic [NW-1:0] SENT_NODE = NW'(POOL_SLOTS);

   // sequencer and item registers
   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [NW-1:0]     s_ff, s_in;
   logic [NW-1:0]     prev_ff, prev_in;
   logic [SLOT_W-1:0] slot_req_ff, slot_req_in;

   // list heads and per-slot flags
   logic [NW-1:0]         free_top_ff, free_top_in;
   logic [NW-1:0]         oldest_ff, oldest_in;
   logic [NW-1:0]         newest_ff, newest_in;
   logic [POOL_SLOTS-1:0] live_ff, live_in;
   logic [POOL_SLOTS-1:0] written_ff, written_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic              rsp_reclaimed_ff, rsp_reclaimed_in;
   logic              rsp_bad_ff, rsp_bad_in;

   // link ram ports
   logic          n_we, o_we;
   logic [SW-1:0] n_waddr, o_waddr;
   logic [NW-1:0] n_wdata, o_wdata;
   logic [NW-1:0] n_rdata, o_rdata;
   logic [SW-1:0] rd_addr;

   logic          accept;
   logic [XW-1:0] slot_ext;
   logic          slot_ok;
   logic [NW-1:0] slot_node;
   logic [NW-1:0] chain_next;
   logic          out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // never-written free chain entries read as their reset value, slot + 1
   assign chain_next = written_ff[s_ff[SW-1:0]] ? n_rdata : s_ff + NW'(1);

   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      s_in             = s_ff;
      prev_in          = prev_ff;
      slot_req_in      = slot_req_ff;
      free_top_in      = free_top_ff;
      oldest_in        = oldest_ff;
      newest_in        = newest_ff;
      live_in          = live_ff;
      written_in       = written_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_slot_in      = rsp_slot_ff;
      rsp_reclaimed_in = rsp_reclaimed_ff;
      rsp_bad_in       = rsp_bad_ff;
      n_we             = 1'b0;
      n_waddr          = s_ff[SW-1:0];
      n_wdata          = SENT_NODE;
      o_we             = 1'b0;
      o_waddr          = s_ff[SW-1:0];
      o_wdata          = SENT_NODE;

      // decode the request against the current heads
      slot_ext  = XW'(req_slot_to_free);
      slot_ok   = slot_ext < XW'(POOL_SLOTS);
      slot_node = NW'(req_slot_to_free);
      if (accept) begin
         if (req_action == ACT_ALLOC) begin
            if (free_top_ff != SENT_NODE) begin
               op_in = OP_TAKE;
               s_in  = free_top_ff;
            end else begin
               op_in = OP_RECLAIM;
               s_in  = oldest_ff;
            end
         end else begin
            s_in = slot_node;
            if (slot_ok && live_ff[slot_node[SW-1:0]]) begin
               op_in = OP_RELEASE;
            end else begin
               op_in = OP_REJECT;
            end
         end
      end
      // the links of the chosen slot are read on the accepting edge
      rd_addr = s_in[SW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               slot_req_in = req_slot_to_free;
               state_in    = (op_in == OP_REJECT) ? ST_DONE : ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_TAKE: begin
                  free_top_in = chain_next;
                  n_we        = 1'b1;
                  n_wdata     = SENT_NODE;
                  written_in[s_ff[SW-1:0]] = 1'b1;
                  live_in[s_ff[SW-1:0]]    = 1'b1;
                  if (newest_ff == SENT_NODE) begin
                     oldest_in = s_ff;
                  end
                  newest_in = s_ff;
                  prev_in   = newest_ff;
                  state_in  = ST_LINK;
               end
               OP_RECLAIM: begin
                  // sole live slot: evicting and relinking leaves it as is
                  if (n_rdata != SENT_NODE) begin
                     o_we      = 1'b1;
                     o_waddr   = n_rdata[SW-1:0];
                     o_wdata   = SENT_NODE;
                     n_we      = 1'b1;
                     n_wdata   = SENT_NODE;
                     oldest_in = n_rdata;
                     newest_in = s_ff;
                     prev_in   = newest_ff;
                     state_in  = ST_LINK;
                  end else begin
                     state_in  = ST_DONE;
                  end
               end
               OP_RELEASE: begin
                  // unlink: newer neighbour gets the older one and back
                  if (n_rdata != SENT_NODE) begin
                     o_we    = 1'b1;
                     o_waddr = n_rdata[SW-1:0];
                     o_wdata = o_rdata;
                  end else begin
                     newest_in = o_rdata;
                  end
                  if (o_rdata != SENT_NODE) begin
                     n_we    = 1'b1;
                     n_waddr = o_rdata[SW-1:0];
                     n_wdata = n_rdata;
                  end else begin
                     oldest_in = n_rdata;
                  end
                  live_in[s_ff[SW-1:0]] = 1'b0;
                  prev_in     = free_top_ff;
                  free_top_in = s_ff;
                  state_in    = ST_PUSH;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_LINK: begin
            // hang the slot behind the previous newest
            o_we    = 1'b1;
            o_wdata = prev_ff;
            if (prev_ff != SENT_NODE) begin
               n_we    = 1'b1;
               n_waddr = prev_ff[SW-1:0];
               n_wdata = s_ff;
            end
            state_in = ST_DONE;
         end
         ST_PUSH: begin
            // freed slot points down the free chain
            n_we    = 1'b1;
            n_wdata = prev_ff;
            written_in[s_ff[SW-1:0]] = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_slot_in      = (op_ff == OP_REJECT) ? slot_req_ff : SLOT_W'(s_ff);
               rsp_reclaimed_in = (op_ff == OP_RECLAIM);
               rsp_bad_in       = (op_ff == OP_REJECT);
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_top_ff  <= '0;
         oldest_ff    <= SENT_NODE;
         newest_ff    <= SENT_NODE;
         live_ff      <= '0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_top_ff  <= free_top_in;
         oldest_ff    <= oldest_in;
         newest_ff    <= newest_in;
         live_ff      <= live_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      s_ff             <= s_in;
      prev_ff          <= prev_in;
      slot_req_ff      <= slot_req_in;
      rsp_slot_ff      <= rsp_slot_in;
      rsp_reclaimed_ff <= rsp_reclaimed_in;
      rsp_bad_ff       <= rsp_bad_in;
   end

   // newer links, doubling as the free chain
   speo_link_ram #(
      .DEPTH (POOL_SLOTS),
      .WIDTH (NW)
   ) u_newer_ram (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_waddr),
      .wr_data (n_wdata),
      .rd_addr (rd_addr),
      .rd_data (n_rdata)
   );

   // older links
   speo_link_ram #(
      .DEPTH (POOL_SLOTS),
      .WIDTH (NW)
   ) u_older_ram (
      .clock   (clock),
      .wr_en   (o_we),
      .wr_addr (o_waddr),
      .wr_data (o_wdata),
      .rd_addr (rd_addr),
      .rd_data (o_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_reclaimed  = rsp_reclaimed_ff;
   assign rsp_bad_free   = rsp_bad_ff;

`ifndef SYNTHESIS
   // the free list top is never a live slot
   a_top_not_live: assert property (@(posedge clock) disable iff (reset)
      (free_top_ff != SENT_NODE) |-> !live_ff[free_top_ff[SW-1:0]])
      else $error("free list top is a live slot");

   // both ends of the age list are empty together
   a_ends_agree: assert property (@(posedge clock) disable iff (reset)
      (oldest_ff == SENT_NODE) == (newest_ff == SENT_NODE))
      else $error("age list ends disagree");

   // eviction only ever meets a non-empty age list
   a_reclaim_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && op_ff == OP_RECLAIM) |-> (oldest_ff != SENT_NODE))
      else $error("reclaim with empty age list");

   // a new response only comes out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside done state");
`endif

endmodule

// ----- tb/sv/slot_pool_evict_oldest_core_tb.sv -----
module slot_pool_evict_oldest_core_tb
   import speo_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // pool geometry; node HUB is both the age-list anchor and the empty marker
   localparam int         SLOTS       = 32;
   localparam logic [5:0] HUB         = 6'd32;
   localparam int         ITEM_TARGET = 1650;
   localparam int         CHUNK_ITEMS = 100;

   // how the generator wants the next item filled in once it reaches the port
   typedef enum logic [2:0] {
      K_ALLOC,      // allocate, slot field is noise
      K_FREE_AT,    // free of a fixed slot
      K_FREE_LIVE,  // free of some slot that is live when the item goes out
      K_FREE_DEAD,  // free of some slot that is not live
      K_FREE_ANY    // free of any slot number
   } item_kind_type;

   typedef struct packed {
      item_kind_type     kind;
      logic [SLOT_W-1:0] slot;
   } pool_item_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              reclaimed;
      logic              bad_free;
   } grant_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic              req_action       = ACT_ALLOC;
   logic [SLOT_W-1:0] req_slot_to_free = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic [SLOT_W-1:0] rsp_slot_index;
   logic              rsp_reclaimed;
   logic              rsp_bad_free;

   slot_pool_evict_oldest_core #(.POOL_SLOTS(SLOTS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_slot_to_free(req_slot_to_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_reclaimed   (rsp_reclaimed),
      .rsp_bad_free    (rsp_bad_free)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // shadow of the pool: age circle through HUB, free stack, live bits
   // ---------------------------------------------------------------------
   logic [5:0] age_newer [0:SLOTS];   // age_newer[HUB] is the oldest live slot
   logic [5:0] age_older [0:SLOTS];   // age_older[HUB] is the newest live slot
   logic [5:0] free_next [0:SLOTS-1];
   logic [5:0] free_head;
   logic       slot_live [0:SLOTS-1];

   pool_item_type pending_items[$];   // items not yet put on the port
   grant_type     expected_grants[$]; // results owed by the block, oldest first

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int useful_items   = 0;            // allocates and good frees accepted
   int fail_count     = 0;
   int n_take = 0, n_reclaim = 0, n_release = 0, n_reject = 0;

   function automatic logic [5:0] clip_node(logic [5:0] v);
      return (v <= HUB) ? v : HUB;
   endfunction

   function automatic void pool_clear();
      for (int i = 0; i <= SLOTS; i++) begin
         age_newer[i] = '0;
         age_older[i] = '0;
      end
      age_newer[HUB] = HUB;
      age_older[HUB] = HUB;
      for (int i = 0; i < SLOTS; i++) begin
         free_next[i] = 6'(i + 1);
         slot_live[i] = 1'b0;
      end
      free_head = '0;
   endfunction

   function automatic void age_unlink(logic [5:0] s);
      logic [5:0] nw;
      logic [5:0] od;
      nw = clip_node(age_newer[s]);
      od = clip_node(age_older[s]);
      age_older[nw] = od;
      age_newer[od] = nw;
   endfunction

   function automatic void age_push_newest(logic [5:0] s);
      logic [5:0] prev;
      prev = clip_node(age_older[HUB]);
      age_newer[s]    = HUB;
      age_older[s]    = prev;
      age_newer[prev] = s;
      age_older[HUB]  = s;
   endfunction

   // one accepted item against the shadow pool; returns the owed result
   function automatic grant_type pool_apply(logic action, logic [SLOT_W-1:0] idx);
      grant_type  g;
      logic [5:0] s;
      g = '0;
      if (action == ACT_ALLOC) begin
         if (free_head < HUB) begin
            s         = free_head;
            free_head = clip_node(free_next[s]);
            n_take++;
         end else begin
            // every slot is live, so the oldest one is taken back
            s = clip_node(age_newer[HUB]);
            if (s >= HUB) s = '0;
            else          age_unlink(s);
            g.reclaimed = 1'b1;
            n_reclaim++;
         end
         age_push_newest(s);
         slot_live[s] = 1'b1;
      end else begin
         s = {1'b0, idx};
         if (slot_live[s]) begin
            age_unlink(s);
            slot_live[s] = 1'b0;
            free_next[s] = free_head;
            free_head    = s;
            n_release++;
         end else begin
            g.bad_free = 1'b1;
            n_reject++;
         end
      end
      g.slot = s[SLOT_W-1:0];
      return g;
   endfunction

   // random slot whose live bit matches, or any slot if there is none
   function automatic logic [SLOT_W-1:0] pick_slot(logic want_live);
      int n;
      int k;
      n = 0;
      for (int i = 0; i < SLOTS; i++) if (slot_live[i] == want_live) n++;
      if (n == 0) return SLOT_W'($urandom_range(SLOTS - 1));
      k = $urandom_range(n - 1);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_live[i] == want_live) begin
            if (k == 0) return SLOT_W'(i);
            k--;
         end
      end
      return '0;
   endfunction

   // ---------------------------------------------------------------------
   // driver: predicts on acceptance, then fills in the next item against
   // the pool as it stands after every earlier item
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      grant_type     g;
      pool_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            g = pool_apply(req_action, req_slot_to_free);
            expected_grants.push_back(g);
            if (!g.bad_free) useful_items++;
         end
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               it = pending_items.pop_front();
               req_valid  <= 1'b1;
               req_action <= (it.kind == K_ALLOC) ? ACT_ALLOC : ACT_FREE;
               case (it.kind)
                  K_FREE_AT:   req_slot_to_free <= it.slot;
                  K_FREE_LIVE: req_slot_to_free <= pick_slot(1'b1);
                  K_FREE_DEAD: req_slot_to_free <= pick_slot(1'b0);
                  default:     req_slot_to_free <= SLOT_W'($urandom_range(SLOTS - 1));
               endcase
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: random back-pressure and in-order field compare
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_responses
      grant_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               $error("result with nothing owed: slot_index %0d", rsp_slot_index);
               fail_count++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_slot_index !== want.slot) begin
                  $error("slot_index expected %0d got %0d", want.slot, rsp_slot_index);
                  fail_count++;
               end
               if (rsp_reclaimed !== want.reclaimed) begin
                  $error("reclaimed expected %0d got %0d", want.reclaimed, rsp_reclaimed);
                  fail_count++;
               end
               if (rsp_bad_free !== want.bad_free) begin
                  $error("bad_free expected %0d got %0d", want.bad_free, rsp_bad_free);
                  fail_count++;
               end
            end
         end
      end
   end

   task automatic push_item(item_kind_type kind, int slot);
      pool_item_type it;
      it.kind = kind;
      it.slot = SLOT_W'(slot);
      pending_items.push_back(it);
   endtask

   // wait until every queued item is in and every result is out
   task automatic drain();
      while (pending_items.size() != 0 || req_valid || expected_grants.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int alloc_pct [0:5];
      int phase;
      int r;
      alloc_pct = '{90, 55, 30, 70, 15, 50};
      pool_clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: fill a little, free from the middle, oldest and newest ends,
      // free slots that are not live (freed twice, never used, lowest and
      // highest numbers), then refill from the free stack in reverse push order
      push_item(K_ALLOC, 0);
      push_item(K_ALLOC, 0);
      push_item(K_ALLOC, 0);
      push_item(K_FREE_AT, 1);   // middle of the age list
      push_item(K_FREE_AT, 1);   // already freed
      push_item(K_FREE_AT, 31);  // never allocated, all bits set
      push_item(K_FREE_AT, 0);   // oldest
      push_item(K_FREE_AT, 2);   // last live slot, list goes empty
      push_item(K_FREE_AT, 0);   // freed, all bits clear
      push_item(K_ALLOC, 0);
      push_item(K_ALLOC, 0);
      push_item(K_ALLOC, 0);
      push_item(K_ALLOC, 0);
      push_item(K_FREE_AT, 3);   // newest
      push_item(K_FREE_AT, 2);
      push_item(K_ALLOC, 0);
      push_item(K_FREE_DEAD, 0);
      push_item(K_FREE_LIVE, 0);
      drain();

      // random chunks; the idle mode turns over every chunk and the
      // allocate share every four, so a full pool (and eviction) comes early
      phase = 0;
      while (phase * CHUNK_ITEMS < ITEM_TARGET) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         for (int i = 0; i < CHUNK_ITEMS; i++) begin
            if ($urandom_range(99) < alloc_pct[(phase / 4) % 6]) begin
               push_item(K_ALLOC, 0);
            end else begin
               r = $urandom_range(99);
               if (r < 85)      push_item(K_FREE_LIVE, 0);
               else if (r < 95) push_item(K_FREE_ANY, 0);
               else             push_item(K_FREE_DEAD, 0);
            end
         end
         drain();
         phase++;
      end

      // settle time for anything stray after the last result
      send_idle_pct = 0;
      repeat (20) @(posedge clock);
      if (expected_grants.size() != 0) begin
         $error("%0d results never arrived", expected_grants.size());
         fail_count++;
      end

      $display("covered %0d allocates from the free list, %0d evictions of the oldest slot,",
               n_take, n_reclaim);
      $display("%0d frees of live slots and %0d rejected frees (%0d effective) over %0d chunks",
               n_release, n_reject, useful_items, phase);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #(2_000_000);
      $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/speo_pkg.sv
hdl/speo_link_ram.sv
hdl/slot_pool_evict_oldest_core.sv
tb/sv/slot_pool_evict_oldest_core_tb.sv
